// File: rtl/mflc_pkg.sv
// ---------------------------------------------------------------------------
// mflc_pkg
// Types and constants shared by the motion fault leaky counter modules.
// ---------------------------------------------------------------------------
package mflc_pkg;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
    logic signed [15:0] vertical_accel;
    logic signed [15:0] left_voltage;
    logic signed [15:0] right_voltage;
    logic        [14:0] supply_voltage;
    logic signed [15:0] speed_integral;
    logic               executing;
    logic               control_on;
    logic               freewheel;
  } mflc_in_t;

  typedef struct packed {
    logic [10:0] fault_count;
    logic        fault_raised;
  } mflc_out_t;

  // Per-item control handed from the penalty logic to the counter.
  typedef struct packed {
    logic       run;    // penalties or decay apply
    logic       clear;  // freewheel clears the counter
    logic [8:0] pen;    // penalty sum, zero means decay
  } mflc_step_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 1'b1;

  localparam logic [10:0] CNT_MAX          = 11'd2047;
  localparam logic [10:0] ERROR_LIMIT_RST  = 11'd1000;
  localparam logic [7:0]  DECAY_STEP_RST   = 8'd2;

  localparam logic [15:0] SPEED_ERR_TH  = 16'd512;   // 2.0
  localparam logic [15:0] REL_MIN_SPEED = 16'd52;    // first code >= 0.20
  localparam logic [15:0] SHOCK_TH      = 16'd7680;  // 30.0
  localparam logic [15:0] VOLT_ABS_TH   = 16'd3072;  // 12.0
  localparam logic [15:0] WINDUP_TH     = 16'd512;   // 2.0

  localparam logic [8:0] PEN_SPEED  = 9'd50;
  localparam logic [8:0] PEN_REL    = 9'd20;
  localparam logic [8:0] PEN_SHOCK  = 9'd30;
  localparam logic [8:0] PEN_VRATIO = 9'd3;
  localparam logic [8:0] PEN_VABS   = 9'd100;
  localparam logic [8:0] PEN_WINDUP = 9'd100;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = 16'(-v);
    return v[15] ? neg : 16'(v);
  endfunction

  function automatic logic [8:0] volt_pen(input logic [15:0] vabs,
                                          input logic [14:0] supply);
    logic [16:0] two_v;
    logic [16:0] three_s;
    logic [8:0]  p;
    two_v   = {vabs, 1'b0};
    three_s = {1'b0, supply, 1'b0} + {2'b00, supply};
    p = 9'd0;
    if (vabs > {1'b0, supply}) begin
      if (two_v > three_s) begin
        p = p + PEN_VRATIO;
      end
      if (vabs > VOLT_ABS_TH) begin
        p = p + PEN_VABS;
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/motion_fault_leaky_counter_unit.sv
// ---------------------------------------------------------------------------
// motion_fault_leaky_counter_unit
// Leaky fault counter over per-tick motion telemetry.
// ---------------------------------------------------------------------------
// One item is accepted every clock cycle when the output side does not stall.
// Each item passes an input register, then the penalty logic and the counter
// update land in the result register; an output stall can hold an item in the
// input register. The counter register is the only loop.
// Configuration writes take effect on the next edge.
module motion_fault_leaky_counter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mflc_pkg::mflc_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mflc_pkg::mflc_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mflc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mflc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                 s1_valid_r;
  mflc_pkg::mflc_in_t   s1_data_r;
  logic                 cnt_ready;
  mflc_pkg::mflc_step_t step;
  logic [10:0]          error_limit_r;
  logic [7:0]           decay_step_r;

  assign in_stall = s1_valid_r && !cnt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_limit_r <= mflc_pkg::ERROR_LIMIT_RST;
      decay_step_r  <= mflc_pkg::DECAY_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mflc_pkg::REG_ERROR_LIMIT: error_limit_r <= cfg_wdata[10:0];
        mflc_pkg::REG_DECAY_STEP:  decay_step_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  mflc_penalty u_penalty (
    .item (s1_data_r),
    .step (step)
  );

  mflc_counter u_counter (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (s1_valid_r),
    .step        (step),
    .error_limit (error_limit_r),
    .decay_step  (decay_step_r),
    .ready       (cnt_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: rtl/mflc_penalty.sv
// ---------------------------------------------------------------------------
// mflc_penalty
// Penalty sum and run/clear decision for one registered input item.
// ---------------------------------------------------------------------------
module mflc_penalty (
  input  mflc_pkg::mflc_in_t   item,
  output mflc_pkg::mflc_step_t step
);

  logic signed [16:0] diff;
  logic        [16:0] diff_neg;
  logic        [15:0] dabs;
  logic        [18:0] dabs_x5;
  logic        [18:0] target_x4;
  logic               rel_hit;
  logic               enabled;
  logic        [8:0]  pen;

  assign diff     = {item.measured_speed[15], item.measured_speed}
                  - {item.target_speed[15], item.target_speed};
  assign diff_neg = 17'(-diff);
  assign dabs     = diff[16] ? diff_neg[15:0] : diff[15:0];

  assign dabs_x5   = {3'b000, dabs} + {1'b0, dabs, 2'b00};
  assign target_x4 = {2'b00, item.target_speed[14:0], 2'b00};
  assign rel_hit   = !item.target_speed[15]
                   && (16'(item.target_speed) >= mflc_pkg::REL_MIN_SPEED)
                   && (dabs_x5 >= target_x4);

  assign enabled = item.executing && item.control_on;

  always_comb begin
    pen = 9'd0;
    if (dabs >= mflc_pkg::SPEED_ERR_TH) begin
      pen = pen + mflc_pkg::PEN_SPEED;
    end
    if (rel_hit) begin
      pen = pen + mflc_pkg::PEN_REL;
    end
    if (mflc_pkg::mag16(item.vertical_accel) >= mflc_pkg::SHOCK_TH) begin
      pen = pen + mflc_pkg::PEN_SHOCK;
    end
    pen = pen + mflc_pkg::volt_pen(mflc_pkg::mag16(item.left_voltage), item.supply_voltage);
    pen = pen + mflc_pkg::volt_pen(mflc_pkg::mag16(item.right_voltage), item.supply_voltage);
    if (mflc_pkg::mag16(item.speed_integral) > mflc_pkg::WINDUP_TH) begin
      pen = pen + mflc_pkg::PEN_WINDUP;
    end
  end

  assign step.run   = enabled && !item.freewheel && (item.target_speed != 16'sd0);
  assign step.clear = enabled && item.freewheel;
  assign step.pen   = pen;

endmodule

// File: rtl/mflc_counter.sv
// ---------------------------------------------------------------------------
// mflc_counter
// Leaky fault counter; the counter register is also the result register.
// ---------------------------------------------------------------------------
module mflc_counter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  mflc_pkg::mflc_step_t step,
  input  logic [10:0]          error_limit,
  input  logic [7:0]           decay_step,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mflc_pkg::mflc_out_t  out_data
);

  logic        cnt_load;
  logic [10:0] cnt_r;
  logic [10:0] cnt_nxt;
  logic        raised_r;
  logic        out_valid_r;
  logic [11:0] sum;

  assign ready    = !out_valid_r || !out_stall;
  assign cnt_load = item_valid && ready;
  assign sum      = {1'b0, cnt_r} + {3'b000, step.pen};

  always_comb begin
    cnt_nxt = cnt_r;
    if (step.clear) begin
      cnt_nxt = 11'd0;
    end else if (step.run) begin
      if (step.pen != 9'd0) begin
        cnt_nxt = sum[11] ? mflc_pkg::CNT_MAX : sum[10:0];
      end else if (cnt_r > {3'b000, decay_step}) begin
        cnt_nxt = cnt_r - {3'b000, decay_step};
      end else begin
        cnt_nxt = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 11'd0;
      raised_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cnt_load) begin
      cnt_r       <= cnt_nxt;
      raised_r    <= cnt_nxt >= error_limit;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.fault_count  = cnt_r;
  assign out_data.fault_raised = raised_r;

`ifndef ASSERT_OFF
  a_hold_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    !cnt_load |=> $stable(cnt_r))
    else $error("counter changed without an item");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_load && step.clear |=> cnt_r == 11'd0)
    else $error("freewheel did not clear counter");

  a_penalty_up: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_load && !step.clear && step.run && step.pen != 9'd0 |=> cnt_r >= $past(cnt_r))
    else $error("penalty lowered counter");

  a_decay_down: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_load && !step.clear && step.run && step.pen == 9'd0 |=> cnt_r <= $past(cnt_r))
    else $error("decay raised counter");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> raised_r == (cnt_r >= error_limit))
    else $error("fault flag disagrees with counter");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for motion_fault_leaky_counter_unit. A driver feeds
// telemetry items from a queue and a monitor checks each result against a
// local model of the leaky fault counter. The run covers several register
// settings, random idling on both sides, and a long output stall.
// ---------------------------------------------------------------------------
module testbench;

  localparam int RUN_LIMIT       = 200000;
  localparam int LONG_HOLD       = 60;
  localparam int PHASES          = 7;
  localparam int TICKS_PER_PHASE = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mflc_pkg::mflc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mflc_pkg::mflc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [mflc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mflc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  motion_fault_leaky_counter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  mflc_pkg::mflc_in_t  tick_q[$];
  mflc_pkg::mflc_out_t expected_q[$];

  int fault_level = 0;
  int limit_reg   = 1000;
  int decay_reg   = 2;

  bit jitter_on = 1'b1;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int sink_gap = 0;
  int src_gap = 0;
  bit in_fire = 1'b0;

  int cycles = 0;
  int fail_cnt = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int flag_hits = 0;
  int sat_hits = 0;

  function automatic int mag_of(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int motor_penalty(input int vabs, input int supply);
    int p;
    p = 0;
    if (vabs > supply) begin
      if (2 * vabs > 3 * supply) p += 3;
      if (vabs > 3072) p += 100;
    end
    return p;
  endfunction

  // Advances the local counter by one tick and returns the expected result.
  function automatic mflc_pkg::mflc_out_t next_fault_state(input mflc_pkg::mflc_in_t t);
    int tgt;
    int dabs;
    int supply;
    int pen;
    mflc_pkg::mflc_out_t r;
    if (t.executing && t.control_on) begin
      if (t.freewheel) begin
        fault_level = 0;
      end else if (t.target_speed != 0) begin
        tgt    = int'($signed(t.target_speed));
        dabs   = mag_of(int'($signed(t.measured_speed)) - tgt);
        supply = int'(t.supply_voltage);
        pen = 0;
        if (dabs >= 512) pen += 50;
        if (tgt >= 52 && 5 * dabs >= 4 * tgt) pen += 20;
        if (mag_of(int'($signed(t.vertical_accel))) >= 7680) pen += 30;
        pen += motor_penalty(mag_of(int'($signed(t.left_voltage))), supply);
        pen += motor_penalty(mag_of(int'($signed(t.right_voltage))), supply);
        if (mag_of(int'($signed(t.speed_integral))) > 512) pen += 100;
        if (pen != 0) begin
          fault_level = fault_level + pen > 2047 ? 2047 : fault_level + pen;
        end else begin
          fault_level = fault_level > decay_reg ? fault_level - decay_reg : 0;
        end
      end
    end
    r.fault_count  = 11'(fault_level);
    r.fault_raised = fault_level >= limit_reg;
    return r;
  endfunction

  function automatic mflc_pkg::mflc_in_t quiet_tick(input int tgt);
    mflc_pkg::mflc_in_t t;
    t = '0;
    t.target_speed   = 16'(tgt);
    t.measured_speed = 16'(tgt);
    t.supply_voltage = 15'h7fff;
    t.executing      = 1'b1;
    t.control_on     = 1'b1;
    return t;
  endfunction

  function automatic int signed_range(input int unsigned lo, input int unsigned hi);
    return ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(lo, hi));
  endfunction

  function automatic logic [15:0] random_volt(input int sup);
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return 16'(signed_range(0, sup));
    if (r < 19) return 16'(signed_range(sup + 1, sup + sup / 2 + 2));
    return 16'($urandom);
  endfunction

  // Mostly running ticks with values clustered around the thresholds,
  // plus a share of fully random noise.
  function automatic mflc_pkg::mflc_in_t random_tick();
    mflc_pkg::mflc_in_t t;
    int tgt;
    int d;
    int sup;
    int r;
    t = '0;
    if ($urandom_range(0, 99) < 8) begin
      t.target_speed   = 16'($urandom);
      t.measured_speed = 16'($urandom);
      t.vertical_accel = 16'($urandom);
      t.left_voltage   = 16'($urandom);
      t.right_voltage  = 16'($urandom);
      t.supply_voltage = 15'($urandom);
      t.speed_integral = 16'($urandom);
      t.executing      = 1'($urandom);
      t.control_on     = 1'($urandom);
      t.freewheel      = 1'($urandom);
      return t;
    end
    t.executing  = $urandom_range(0, 19) != 0;
    t.control_on = $urandom_range(0, 19) != 0;
    t.freewheel  = $urandom_range(0, 39) == 0;
    case ($urandom_range(0, 9))
      0: tgt = 0;
      1, 2: tgt = $urandom_range(40, 64);
      3: tgt = int'($signed(16'($urandom)));
      default: tgt = signed_range(0, 750);
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: d = signed_range(0, 100);
      3: d = signed_range(500, 524);
      4: d = -(tgt * 4 / 5) + int'($urandom_range(0, 4)) - 2;
      5: d = int'($signed(16'($urandom)));
      default: d = signed_range(0, 500);
    endcase
    t.target_speed   = 16'(tgt);
    t.measured_speed = 16'(tgt + d);
    r = $urandom_range(0, 19);
    if (r < 17) t.vertical_accel = 16'(signed_range(0, 7000));
    else if (r < 19) t.vertical_accel = 16'(signed_range(7670, 7690));
    else t.vertical_accel = 16'($urandom);
    sup = $urandom_range(0, 19) == 0 ? $urandom_range(0, 32767) : $urandom_range(1700, 3300);
    t.supply_voltage = 15'(sup);
    t.left_voltage   = random_volt(sup);
    t.right_voltage  = random_volt(sup);
    r = $urandom_range(0, 19);
    if (r < 17) t.speed_integral = 16'(signed_range(0, 512));
    else if (r < 19) t.speed_integral = 16'(signed_range(513, 600));
    else t.speed_integral = 16'($urandom);
    return t;
  endfunction

  task automatic write_reg(input logic [mflc_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    if (idx == mflc_pkg::REG_DECAY_STEP) begin
      cfg_wdata = {3'($urandom), 8'(val)};
      decay_reg = int'(cfg_wdata[7:0]);
    end else begin
      cfg_wdata = 11'(val);
      limit_reg = int'(cfg_wdata);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    logic nv;
    mflc_pkg::mflc_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_fire) nv = 1'b0;
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (tick_q.size() != 0) begin
          if (jitter_on && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 2);
          end else begin
            nd = tick_q.pop_front();
            nv = 1'b1;
          end
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // receiver stall
  always @(negedge clk) begin
    logic ns;
    ns = 1'b0;
    if (rst_n) begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        ns = 1'b1;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 2);
        ns = 1'b1;
      end
    end
    out_stall <= ns;
  end

  // monitor
  always @(posedge clk) begin
    mflc_pkg::mflc_out_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      expected_q.push_back(next_fault_state(in_data));
      ticks_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: fault_count %0d", out_data.fault_count);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.fault_count !== want.fault_count) begin
          $error("fault_count: expected %0d, actual %0d", want.fault_count,
                 out_data.fault_count);
          fail_cnt++;
        end
        if (out_data.fault_raised !== want.fault_raised) begin
          $error("fault_raised: expected %0d, actual %0d", want.fault_raised,
                 out_data.fault_raised);
          fail_cnt++;
        end
        if (want.fault_raised) flag_hits++;
        if (want.fault_count == mflc_pkg::CNT_MAX) sat_hits++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mflc_pkg::mflc_in_t t;
    int unsigned lim_set [PHASES];
    int unsigned dec_set [PHASES];
    lim_set = '{2047, 1, 0, 0, 300, 0, 1000};
    dec_set = '{0, 255, 1, 0, 7, 0, 2};
    lim_set[3] = $urandom_range(2, 2046);
    lim_set[5] = $urandom_range(2, 2046);
    dec_set[3] = $urandom_range(0, 255);
    dec_set[5] = $urandom_range(3, 60);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed items under the reset register values
    t = quiet_tick(300); t.executing = 1'b0; t.speed_integral = 16'd2000; tick_q.push_back(t);
    t = quiet_tick(300); t.control_on = 1'b0; t.vertical_accel = 16'h8000; tick_q.push_back(t);
    t = quiet_tick(0); t.speed_integral = 16'h7fff; t.measured_speed = 16'd3000;
    tick_q.push_back(t);
    t = quiet_tick(32767);
    t.measured_speed = 16'h8000; t.vertical_accel = 16'h8000;
    t.left_voltage = 16'h8000; t.right_voltage = 16'h8000;
    t.supply_voltage = '0; t.speed_integral = 16'h7fff;
    repeat (6) tick_q.push_back(t);
    tick_q.push_back(quiet_tick(100));
    t = quiet_tick(100); t.freewheel = 1'b1; t.speed_integral = 16'h7fff; tick_q.push_back(t);
    tick_q.push_back(quiet_tick(-200));
    t = quiet_tick(1000); t.measured_speed = 16'd489; tick_q.push_back(t);
    t = quiet_tick(1000); t.measured_speed = 16'd1512; tick_q.push_back(t);
    t = quiet_tick(51); t.measured_speed = 16'(-400); tick_q.push_back(t);
    t = quiet_tick(52); t.measured_speed = 16'd10; tick_q.push_back(t);
    t = quiet_tick(52); t.measured_speed = 16'd11; tick_q.push_back(t);
    t = quiet_tick(-32768); t.measured_speed = 16'h7fff; tick_q.push_back(t);
    t = quiet_tick(200); t.vertical_accel = 16'd7679; tick_q.push_back(t);
    t = quiet_tick(200); t.vertical_accel = 16'(-7680); tick_q.push_back(t);
    t = quiet_tick(500); t.supply_voltage = 15'd1000; t.left_voltage = 16'd1001;
    tick_q.push_back(t);
    t = quiet_tick(500); t.supply_voltage = 15'd1000; t.left_voltage = 16'(-1501);
    tick_q.push_back(t);
    t = quiet_tick(500); t.supply_voltage = 15'd3000; t.right_voltage = 16'd3073;
    tick_q.push_back(t);
    t = quiet_tick(500); t.right_voltage = 16'h8000; tick_q.push_back(t);
    t = quiet_tick(500); t.speed_integral = 16'd512; tick_q.push_back(t);
    t = quiet_tick(500); t.speed_integral = 16'(-513); tick_q.push_back(t);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(mflc_pkg::REG_ERROR_LIMIT, lim_set[p]);
      write_reg(mflc_pkg::REG_DECAY_STEP, dec_set[p]);
      jitter_on = p != PHASES - 1;
      if (p == 3) hold_asked++;
      repeat (TICKS_PER_PHASE) tick_q.push_back(random_tick());
      wait_drained();
    end
    repeat (10) @(posedge clk);

    $display("Ran %0d telemetry items over %0d register settings, %0d results checked.",
             ticks_sent, PHASES + 1, results_seen);
    $display("Fault flag expected set on %0d results, counter at its ceiling on %0d.",
             flag_hits, sat_hits);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
